// ----- rtl/imu_complementary_tilt_filter_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the tilt filter checker
// Each macro samples on aclk and is disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef IMU_COMPLEMENTARY_TILT_FILTER_DEFINES_SVH
`define IMU_COMPLEMENTARY_TILT_FILTER_DEFINES_SVH

// same-cycle implication
`define CTF_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CTF_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/ctf_pkg.sv -----
// ----------------------------------------------------------------------------
// ctf_pkg
// Shared constants, types and the arctangent table of the tilt filter.
// ----------------------------------------------------------------------------
package ctf_pkg;

    localparam int CORDIC_STEPS = 20;     // 12 .. 32
    localparam int ITER_W       = 5;
    localparam int CW           = 28;     // CORDIC x/y datapath
    localparam int ZW           = 26;     // CORDIC angle accumulator
    localparam int ACC_W        = 27;     // accel angle minus bias
    localparam int INC_W        = 28;     // gyro angle increment
    localparam int SUM_W        = 34;
    localparam int DIV_W        = 40;
    localparam int SQ_W         = 32;
    localparam int ROOT_W       = 24;
    localparam int PROD_W       = 46;

    localparam int RATE_SHIFT   = 12;     // 536576 = 131 * 2^12
    localparam int RATE_HALF    = 268288;
    localparam int BLEND_HALF   = 12;
    localparam int YAW_GATE_MAG = 20121;  // |d| * 10 > 201216
    localparam int STEP_TIME_RST = 8389;
    localparam int DEG90        = 90 * 65536;

    // reciprocals: exact floor quotients for the operand ranges used
    localparam logic [31:0] RECIP_131       = 32'd4196609267;  // ceil(2^39 / 131), n < 2^32
    localparam int          RECIP_131_SHIFT = 39;
    localparam logic [31:0] RECIP_25        = 32'd2684355;     // ceil(2^26 / 25), n < 2^21
    localparam int          RECIP_25_SHIFT  = 26;
    localparam int          BLEND_SPLIT     = 20;              // 2^20 = 25 * 41943 + 1
    localparam int          BLEND_SPLIT_Q   = 41943;

    localparam logic [2:0] REG_GYRO_X_BIAS = 3'd0;
    localparam logic [2:0] REG_GYRO_Y_BIAS = 3'd1;
    localparam logic [2:0] REG_GYRO_Z_BIAS = 3'd2;
    localparam logic [2:0] REG_PITCH_BIAS  = 3'd3;
    localparam logic [2:0] REG_ROLL_BIAS   = 3'd4;
    localparam logic [2:0] REG_STEP_TIME   = 3'd5;

    typedef struct packed {
        logic start;
        logic by_rate;   // 1: divide by 131, 0: divide by 25
    } div_cmd_t;

    function automatic logic signed [22:0] atan_tab(input logic [ITER_W-1:0] i);
        logic signed [22:0] v;
        case (i)
            5'd0:    v = 23'sd2949120;
            5'd1:    v = 23'sd1740967;
            5'd2:    v = 23'sd919879;
            5'd3:    v = 23'sd466945;
            5'd4:    v = 23'sd234379;
            5'd5:    v = 23'sd117304;
            5'd6:    v = 23'sd58666;
            5'd7:    v = 23'sd29335;
            5'd8:    v = 23'sd14668;
            5'd9:    v = 23'sd7334;
            5'd10:   v = 23'sd3667;
            5'd11:   v = 23'sd1833;
            5'd12:   v = 23'sd917;
            5'd13:   v = 23'sd458;
            5'd14:   v = 23'sd229;
            5'd15:   v = 23'sd115;
            5'd16:   v = 23'sd57;
            5'd17:   v = 23'sd29;
            5'd18:   v = 23'sd14;
            5'd19:   v = 23'sd7;
            5'd20:   v = 23'sd4;
            5'd21:   v = 23'sd2;
            5'd22:   v = 23'sd1;
            default: v = 23'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
        logic signed [31:0] r;
        if (v > 41'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -41'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// ----- rtl/imu_complementary_tilt_filter.sv -----
// ----------------------------------------------------------------------------
// imu_complementary_tilt_filter
// Complementary pitch/roll/yaw filter for a six-axis inertial sample stream.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one raw sample per request. s_tdata carries the six raw words,
//   s_tuser[0] the sample-valid flag; a clear flag reuses the last latched
//   sample (all zero after reset).
//   m_ channel: one result per request, pitch/roll/yaw in Q16.16 degrees and
//   the connected flag in m_tuser[0].
//   Configuration: APB registers at byte offsets 0x00..0x14 (gyro x/y/z bias,
//   pitch bias, roll bias, step time). Write only while the block is idle.
// Timing:
//   s_tready is high only while the sequencer is idle; a request runs through
//   squares, sqrt, two CORDIC passes (shortened when both operands are zero),
//   three rate and two blend divisions on the divider with their set-up steps,
//   yaw, load and idle before the next accept. sqrt and CORDIC dominate.
// Reset: synchronous active-low aresetn clears the angle stores, the latched
//   sample and the sequencer; step time returns to 8389, biases to zero.
// Back-pressure: the result sits in the output register; a later request
//   is accepted meanwhile and only waits at its final load if m_tready
//   is still low.
// ----------------------------------------------------------------------------
module imu_complementary_tilt_filter (
    input  logic        aclk,
    input  logic        aresetn,
    // sample stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
    input  logic [0:0]  s_tuser,   // sample_valid
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // pitch_angle, roll_angle, yaw_angle
    output logic [0:0]  m_tuser,   // connected
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ctf_pkg::*;

    typedef enum logic [14:0] {
        ST_IDLE  = 15'h0001,
        ST_SQA   = 15'h0002,
        ST_SQB   = 15'h0004,
        ST_SQC   = 15'h0008,
        ST_SQRT  = 15'h0010,
        ST_CORP  = 15'h0020,
        ST_CORR  = 15'h0040,
        ST_MUL   = 15'h0080,
        ST_DIVA  = 15'h0100,
        ST_SUM   = 15'h0200,
        ST_SCALE = 15'h0400,
        ST_ADDA  = 15'h0800,
        ST_DIVB  = 15'h1000,
        ST_YAW   = 15'h2000,
        ST_OUT   = 15'h4000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic signed [23:0] gx_bias_reg, gy_bias_reg, gz_bias_reg;
    logic signed [24:0] pitch_bias_reg, roll_bias_reg;
    logic [19:0]        step_time_reg;

    // latched sample and filter state
    logic signed [15:0] smp_reg [6];
    logic               conn_reg;
    logic signed [31:0] pitch_reg, roll_reg, yaw_reg;

    // working registers
    logic signed [PROD_W-1:0] prod_reg;
    logic [SQ_W-1:0]          sq_reg;
    logic signed [ACC_W-1:0]  acc_p_reg, acc_r_reg;
    logic signed [INC_W-1:0]  inc_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [DIV_W-1:0]  t_reg;
    logic [1:0]               axis_reg;
    logic                     div_neg_reg;
    logic                     sqrt_go_reg, cor_go_reg, div_go_reg;

    // output register
    logic        m_valid_reg;
    logic [95:0] m_data_reg;
    logic        m_user_reg;

    logic s_fire, m_load, cfg_wr;
    assign s_fire = s_tvalid && s_tready;
    assign cfg_wr = psel && penable && pwrite;
    assign m_load = (state_reg == ST_OUT) && (!m_valid_reg || m_tready);

    // ---------------- shared multiplier ----------------
    logic signed [24:0]       mul_a;
    logic signed [20:0]       mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [15:0]       raw_sel;
    logic signed [23:0]       bias_sel;
    logic signed [24:0]       d_sel;
    logic [24:0]              d_abs;

    always_comb begin
        case (axis_reg)
            2'd0:    begin raw_sel = smp_reg[3]; bias_sel = gx_bias_reg; end
            2'd1:    begin raw_sel = smp_reg[4]; bias_sel = gy_bias_reg; end
            default: begin raw_sel = smp_reg[5]; bias_sel = gz_bias_reg; end
        endcase
    end

    assign d_sel = $signed({raw_sel, 8'd0}) - 25'(bias_sel);
    assign d_abs = d_sel[24] ? 25'(-d_sel) : d_sel;

    always_comb begin
        case (state_reg)
            ST_SQA:  begin mul_a = 25'(smp_reg[0]); mul_b = 21'(smp_reg[0]); end
            ST_SQB:  begin mul_a = 25'(smp_reg[2]); mul_b = 21'(smp_reg[2]); end
            default: begin mul_a = d_sel; mul_b = $signed({1'b0, step_time_reg}); end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // ---------------- square root ----------------
    logic              sqrt_done;
    logic [ROOT_W-1:0] sqrt_root;

    ctf_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqrt_go_reg),
        .sq      (sq_reg),
        .done    (sqrt_done),
        .root    (sqrt_root)
    );

    // ---------------- CORDIC ----------------
    logic signed [24:0]   cor_y, cor_x;
    logic                 cor_done;
    logic signed [ZW-1:0] cor_z;

    // pitch: atan2(ay, r); roll: atan2(ax, az)
    assign cor_y = (state_reg == ST_CORP) ? $signed({smp_reg[1][15], smp_reg[1], 8'd0})
                                          : $signed({smp_reg[0][15], smp_reg[0], 8'd0});
    assign cor_x = (state_reg == ST_CORP) ? $signed({1'b0, sqrt_root})
                                          : $signed({smp_reg[2][15], smp_reg[2], 8'd0});

    ctf_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cor_go_reg),
        .y_in    (cor_y),
        .x_in    (cor_x),
        .done    (cor_done),
        .z       (cor_z)
    );

    // ---------------- divider ----------------
    logic [PROD_W-1:0]  prod_abs;
    logic [PROD_W:0]    rate_num;
    logic [DIV_W-1:0]   t_abs;
    logic [DIV_W-1:0]   div_in;
    logic               div_in_neg;
    div_cmd_t           div_cmd;
    logic               div_done;
    logic [DIV_W-1:0]   div_q;
    logic signed [DIV_W:0] q_s;

    assign prod_abs   = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : prod_reg;
    assign rate_num   = (PROD_W+1)'(prod_abs) + (PROD_W+1)'(RATE_HALF);
    assign t_abs      = t_reg[DIV_W-1] ? DIV_W'(-t_reg) : t_reg;
    assign div_in     = (state_reg == ST_DIVA) ? DIV_W'(rate_num >> RATE_SHIFT)
                                               : t_abs + DIV_W'(BLEND_HALF);
    assign div_in_neg = (state_reg == ST_DIVA) ? prod_reg[PROD_W-1] : t_reg[DIV_W-1];

    assign div_cmd.start   = div_go_reg;
    assign div_cmd.by_rate = (state_reg == ST_DIVA);

    ctf_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (div_cmd),
        .dividend (div_in),
        .done     (div_done),
        .quotient (div_q)
    );

    // rounded magnitude back to signed
    assign q_s = div_neg_reg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});

    logic signed [31:0]      store_k;
    logic signed [ACC_W-1:0] acc_k;
    assign store_k = (axis_reg == 2'd0) ? pitch_reg : roll_reg;
    assign acc_k   = (axis_reg == 2'd0) ? acc_p_reg : acc_r_reg;

    // ---------------- sequencer ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_fire) state_next = ST_SQA;
            ST_SQA:   state_next = ST_SQB;
            ST_SQB:   state_next = ST_SQC;
            ST_SQC:   state_next = ST_SQRT;
            ST_SQRT:  if (sqrt_done) state_next = ST_CORP;
            ST_CORP:  if (cor_done) state_next = ST_CORR;
            ST_CORR:  if (cor_done) state_next = ST_MUL;
            ST_MUL:   state_next = ST_DIVA;
            ST_DIVA:  if (div_done) state_next = (axis_reg == 2'd2) ? ST_YAW : ST_SUM;
            ST_SUM:   state_next = ST_SCALE;
            ST_SCALE: state_next = ST_ADDA;
            ST_ADDA:  state_next = ST_DIVB;
            ST_DIVB:  if (div_done) state_next = ST_MUL;
            ST_YAW:   state_next = ST_OUT;
            ST_OUT:   if (m_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            sqrt_go_reg <= 1'b0;
            cor_go_reg  <= 1'b0;
            div_go_reg  <= 1'b0;
            axis_reg    <= 2'd0;
            m_valid_reg <= 1'b0;
            pitch_reg   <= '0;
            roll_reg    <= '0;
            yaw_reg     <= '0;
            conn_reg    <= 1'b0;
            for (int i = 0; i < 6; i++) smp_reg[i] <= '0;
        end else begin
            state_reg   <= state_next;
            sqrt_go_reg <= (state_next == ST_SQRT) && (state_reg != ST_SQRT);
            cor_go_reg  <= ((state_next == ST_CORP) && (state_reg != ST_CORP)) ||
                           ((state_next == ST_CORR) && (state_reg != ST_CORR));
            div_go_reg  <= ((state_next == ST_DIVA) && (state_reg != ST_DIVA)) ||
                           ((state_next == ST_DIVB) && (state_reg != ST_DIVB));

            if (div_go_reg) div_neg_reg <= div_in_neg;

            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        conn_reg <= s_tuser[0];
                        axis_reg <= 2'd0;
                        if (s_tuser[0]) begin
                            for (int i = 0; i < 6; i++) smp_reg[i] <= s_tdata[16*i +: 16];
                        end
                    end
                end
                ST_SQA: prod_reg <= mul_p;
                ST_SQB: begin
                    sq_reg   <= prod_reg[SQ_W-1:0];
                    prod_reg <= mul_p;
                end
                ST_SQC: sq_reg <= sq_reg + prod_reg[SQ_W-1:0];
                ST_CORP: if (cor_done) acc_p_reg <= ACC_W'(cor_z) - ACC_W'(pitch_bias_reg);
                ST_CORR: if (cor_done) acc_r_reg <= ACC_W'(cor_z) - ACC_W'(roll_bias_reg);
                ST_MUL:  prod_reg <= mul_p;
                ST_DIVA: if (div_done) inc_reg <= q_s[INC_W-1:0];
                ST_SUM:  sum_reg <= SUM_W'(store_k) + SUM_W'(inc_reg);
                ST_SCALE: t_reg <= (DIV_W'(sum_reg) <<< 4) + (DIV_W'(sum_reg) <<< 3);
                ST_ADDA: t_reg <= t_reg + DIV_W'(acc_k);
                ST_DIVB: begin
                    if (div_done) begin
                        if (axis_reg == 2'd0) pitch_reg <= sat32(q_s);
                        else                  roll_reg  <= sat32(q_s);
                        axis_reg <= axis_reg + 1'b1;
                    end
                end
                ST_YAW: begin
                    // dead band on the z rate
                    if (d_abs > 25'(YAW_GATE_MAG))
                        yaw_reg <= sat32(41'(yaw_reg) + 41'(inc_reg));
                end
                default: ;
            endcase

            if (m_load) begin
                m_valid_reg <= 1'b1;
                m_data_reg  <= {yaw_reg, roll_reg, pitch_reg};
                m_user_reg  <= conn_reg;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------- configuration port ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gx_bias_reg    <= '0;
            gy_bias_reg    <= '0;
            gz_bias_reg    <= '0;
            pitch_bias_reg <= '0;
            roll_bias_reg  <= '0;
            step_time_reg  <= 20'(STEP_TIME_RST);
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_GYRO_X_BIAS: gx_bias_reg    <= pwdata[23:0];
                REG_GYRO_Y_BIAS: gy_bias_reg    <= pwdata[23:0];
                REG_GYRO_Z_BIAS: gz_bias_reg    <= pwdata[23:0];
                REG_PITCH_BIAS:  pitch_bias_reg <= pwdata[24:0];
                REG_ROLL_BIAS:   roll_bias_reg  <= pwdata[24:0];
                REG_STEP_TIME:   step_time_reg  <= pwdata[19:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_GYRO_X_BIAS: prdata = {8'd0, gx_bias_reg};
            REG_GYRO_Y_BIAS: prdata = {8'd0, gy_bias_reg};
            REG_GYRO_Z_BIAS: prdata = {8'd0, gz_bias_reg};
            REG_PITCH_BIAS:  prdata = {7'd0, pitch_bias_reg};
            REG_ROLL_BIAS:   prdata = {7'd0, roll_bias_reg};
            REG_STEP_TIME:   prdata = {12'd0, step_time_reg};
            default:         prdata = 32'd0;
        endcase
    end

    assign pready   = 1'b1;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// ----- rtl/ctf_div.sv -----
// ----------------------------------------------------------------------------
// ctf_div
// Division by 131 or 25 through reciprocal multiplication, three steps.
// ----------------------------------------------------------------------------
module ctf_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  ctf_pkg::div_cmd_t         cmd,
    input  logic [ctf_pkg::DIV_W-1:0] dividend,
    output logic                      done,
    output logic [ctf_pkg::DIV_W-1:0] quotient
);
    import ctf_pkg::*;

    localparam int HI_W = DIV_W - BLEND_SPLIT;

    logic [DIV_W-1:0]       num_reg;
    logic                   rate_reg;
    logic [1:0]             step_reg;
    logic                   busy_reg;
    logic                   done_reg;
    logic [BLEND_SPLIT:0]   hl_reg;
    logic [63:0]            pm_reg;
    logic [35:0]            ph_reg;
    logic [DIV_W-1:0]       quo_reg;
    logic [HI_W-1:0]        num_hi;
    logic [BLEND_SPLIT-1:0] num_lo;
    logic [31:0]            mul_a;
    logic [31:0]            mul_b;
    logic [63:0]            mul_p;
    logic [35:0]            hi_q;
    logic [DIV_W-1:0]       q_rate;
    logic [DIV_W-1:0]       q_blend;

    // blend: n = h * 2^20 + l, so n / 25 = h * 41943 + (h + l) / 25
    assign num_hi = num_reg[DIV_W-1 -: HI_W];
    assign num_lo = num_reg[BLEND_SPLIT-1:0];
    assign hi_q   = 36'(num_hi) * 36'(BLEND_SPLIT_Q);

    // rate dividend stays below 2^32
    assign mul_a = rate_reg ? num_reg[31:0] : 32'(hl_reg);
    assign mul_b = rate_reg ? RECIP_131 : RECIP_25;
    assign mul_p = 64'(mul_a) * 64'(mul_b);

    assign q_rate  = DIV_W'(pm_reg >> RECIP_131_SHIFT);
    assign q_blend = DIV_W'(ph_reg) + DIV_W'(pm_reg >> RECIP_25_SHIFT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (cmd.start) begin
                busy_reg <= 1'b1;
                step_reg <= 2'd0;
                num_reg  <= dividend;
                rate_reg <= cmd.by_rate;
            end else if (busy_reg) begin
                case (step_reg)
                    2'd0: begin
                        hl_reg   <= (BLEND_SPLIT+1)'(num_hi) + (BLEND_SPLIT+1)'(num_lo);
                        step_reg <= 2'd1;
                    end
                    2'd1: begin
                        pm_reg   <= mul_p;
                        ph_reg   <= hi_q;
                        step_reg <= 2'd2;
                    end
                    default: begin
                        quo_reg  <= rate_reg ? q_rate : q_blend;
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                endcase
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- rtl/ctf_sqrt.sv -----
// ----------------------------------------------------------------------------
// ctf_sqrt
// Floor integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module ctf_sqrt (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [ctf_pkg::SQ_W-1:0]    sq,     // radicand is sq * 2^16
    output logic                        done,
    output logic [ctf_pkg::ROOT_W-1:0]  root
);
    import ctf_pkg::*;

    localparam int N_W = 2 * ROOT_W;
    localparam int R_W = ROOT_W + 3;

    logic [N_W-1:0]    n_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [R_W-1:0]    rem_reg;
    logic [4:0]        cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [R_W-1:0]    rem_sh;
    logic [R_W-1:0]    trial;
    logic              fits;

    assign rem_sh = {rem_reg[R_W-3:0], n_reg[N_W-1 -: 2]};
    assign trial  = R_W'({root_reg, 2'b01});
    assign fits   = rem_sh >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                n_reg    <= {sq, 16'd0};
                root_reg <= '0;
                rem_reg  <= '0;
            end else if (busy_reg) begin
                rem_reg  <= fits ? rem_sh - trial : rem_sh;
                root_reg <= {root_reg[ROOT_W-2:0], fits};
                n_reg    <= {n_reg[N_W-3:0], 2'b00};
                cnt_reg  <= cnt_reg + 1'b1;
                if (cnt_reg == 5'(ROOT_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ----- rtl/ctf_cordic.sv -----
// ----------------------------------------------------------------------------
// ctf_cordic
// Vectoring CORDIC atan2 in Q16.16 degrees, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module ctf_cordic (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic signed [24:0]          y_in,
    input  logic signed [24:0]          x_in,
    output logic                        done,
    output logic signed [ctf_pkg::ZW-1:0] z
);
    import ctf_pkg::*;

    logic signed [CW-1:0] x_reg, y_reg;
    logic signed [ZW-1:0] z_reg;
    logic [ITER_W-1:0]    iter_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic signed [CW-1:0] xs, ys, x0, y0;
    logic signed [ZW-1:0] ang;

    assign xs  = x_reg >>> iter_reg;
    assign ys  = y_reg >>> iter_reg;
    assign ang = ZW'(atan_tab(iter_reg));
    assign x0  = CW'(x_in);
    assign y0  = CW'(y_in);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                iter_reg <= '0;
                if (x_in == 25'sd0 && y_in == 25'sd0) begin
                    z_reg    <= '0;
                    done_reg <= 1'b1;
                end else begin
                    busy_reg <= 1'b1;
                    if (x_in < 25'sd0) begin
                        // quarter-turn pre-rotation into the right half-plane
                        if (y_in >= 25'sd0) begin
                            x_reg <= y0;
                            y_reg <= -x0;
                            z_reg <= ZW'(DEG90);
                        end else begin
                            x_reg <= -y0;
                            y_reg <= x0;
                            z_reg <= -ZW'(DEG90);
                        end
                    end else begin
                        x_reg <= x0;
                        y_reg <= y0;
                        z_reg <= '0;
                    end
                end
            end else if (busy_reg) begin
                if (y_reg > 0) begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + ang;
                end else begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - ang;
                end
                iter_reg <= iter_reg + 1'b1;
                if (iter_reg == ITER_W'(CORDIC_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign z    = z_reg;

endmodule

// ----- rtl/ctf_checker.sv -----
// ----------------------------------------------------------------------------
// ctf_checker
// Port-level checks of the tilt filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "imu_complementary_tilt_filter_defines.svh"

module ctf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // stalled result holds
    `CTF_ASSERT_NXT(a_m_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // one request in flight: busy right after accept
    `CTF_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "second request taken while busy")

    // no result can appear the cycle after an accept
    `CTF_ASSERT_NXT(a_no_instant_result, s_tvalid && s_tready, !$rose(m_tvalid), "result too early")

endmodule

bind imu_complementary_tilt_filter ctf_checker u_ctf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
